/* rtl/fbt_pkg.sv */
// Package for the Fermat base test core.
// Holds the transfer payload types of the argument and result channels.
// Has no dependencies; the core imports it.
`default_nettype none

package fbt_pkg;

    // One argument transfer: witness base and candidate modulus.
    typedef struct packed {
        logic [31:0] base;
        logic [31:0] modulus;
    } fbt_arg_t;

    // One result transfer.
    typedef struct packed {
        logic probable_prime;
        logic coprime;
    } fbt_res_t;

endpackage

`default_nettype wire

/* rtl/fermat_base_test_core.sv */
// Fermat probable-prime test of one modulus against one base.
// Bit-serial reduction, binary gcd and a bit-serial modular multiplier.
// Depends on fbt_pkg for the channel payload types.
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+---------------------------------
//   arg     | in  | arg_valid/arg_stall | fbt_arg_t: base, modulus
//   res     | out | res_valid/res_stall | fbt_res_t: probable_prime, coprime
//
// One argument is worked on at a time. It reduces the base bit-serially, runs the
// binary gcd, and then works through up to WIDTH exponent bits, each costing one
// or two bit-serial modular products.
// Reset clears the state machine and the result valid flag only.
// A stalled result sits in the output register while the next argument is taken.
`default_nettype none

module fermat_base_test_core
    import fbt_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     arg_valid,
    output logic          arg_stall,
    input  wire fbt_arg_t arg,
    output logic          res_valid,
    input  wire logic     res_stall,
    output fbt_res_t      res
);

    localparam int CW = $clog2(WIDTH);

    // State codes.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_GCD    = 3'd2;
    localparam logic [2:0] ST_PSTEP  = 3'd3;
    localparam logic [2:0] ST_MUL    = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;

    // (x + y) mod n for x, y < n.
    function automatic logic [WIDTH-1:0] add_mod(
        input logic [WIDTH-1:0] x,
        input logic [WIDTH-1:0] y,
        input logic [WIDTH-1:0] n
    );
        logic [WIDTH:0] s;
        logic [WIDTH:0] d;
        s = {1'b0, x} + {1'b0, y};
        d = s - {1'b0, n};
        if (s >= {1'b0, n})
            return d[WIDTH-1:0];
        else
            return s[WIDTH-1:0];
    endfunction

    logic [2:0]       state_reg, state_next;
    logic             res_valid_reg, res_valid_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             sq_mode_reg, sq_mode_next;
    logic [WIDTH-1:0] n_reg, n_next;
    logic [WIDTH-1:0] div_reg, div_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] u_reg, u_next;
    logic [WIDTH-1:0] v_reg, v_next;
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] e_reg, e_next;
    logic [WIDTH-1:0] mx_reg, mx_next;
    logic [WIDTH-1:0] my_reg, my_next;
    logic [WIDTH-1:0] mp_reg, mp_next;
    logic             cop_reg, cop_next;
    logic             prime_reg, prime_next;
    fbt_res_t         res_reg, res_next;

    logic [WIDTH-1:0] base_w;
    logic [WIDTH-1:0] mod_w;
    logic [WIDTH:0]   div_trial;
    logic [WIDTH:0]   div_diff;
    logic [WIDTH-1:0] rem_step;
    logic [WIDTH:0]   gcd_diff;
    logic             res_free;

    // Operands are taken in their low WIDTH bits.
    assign base_w = WIDTH'(arg.base);
    assign mod_w  = WIDTH'(arg.modulus);

    // One restoring division step: bring in the next dividend bit.
    assign div_trial = {rem_reg, div_reg[WIDTH-1]};
    assign div_diff  = div_trial - {1'b0, n_reg};
    assign rem_step  = (div_trial >= {1'b0, n_reg}) ? div_diff[WIDTH-1:0]
                                                    : div_trial[WIDTH-1:0];

    // Difference of the two odd gcd operands; the top bit says which is larger.
    assign gcd_diff = {1'b0, u_reg} - {1'b0, v_reg};

    // The output register can take a new result.
    assign res_free = !res_valid_reg || !res_stall;

    assign arg_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        cnt_next       = cnt_reg;
        sq_mode_next   = sq_mode_reg;
        n_next         = n_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        a_next         = a_reg;
        acc_next       = acc_reg;
        e_next         = e_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        mp_next        = mp_reg;
        cop_next       = cop_reg;
        prime_next     = prime_reg;
        res_next       = res_reg;

        // A waiting result leaves on its transfer.
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (arg_valid)
                begin
                    n_next   = mod_w;
                    div_next = base_w;
                    rem_next = '0;
                    cnt_next = CW'(WIDTH - 1);
                    // A zero modulus leaves the base unreduced.
                    if (mod_w == '0)
                    begin
                        u_next     = base_w;
                        v_next     = '0;
                        state_next = ST_GCD;
                    end
                    else
                    begin
                        state_next = ST_REDUCE;
                    end
                end
            end

            ST_REDUCE:
            begin
                rem_next = rem_step;
                div_next = {div_reg[WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == '0)
                begin
                    a_next     = rem_step;
                    u_next     = rem_step;
                    v_next     = n_reg;
                    state_next = ST_GCD;
                end
            end

            ST_GCD:
            begin
                // Binary gcd; only whether the gcd is one matters.
                if (u_reg == '0 || v_reg == '0 || (!u_reg[0] && !v_reg[0]))
                begin
                    if (u_reg == '0)
                        cop_next = (v_reg == WIDTH'(1));
                    else if (v_reg == '0)
                        cop_next = (u_reg == WIDTH'(1));
                    else
                        cop_next = 1'b0;
                    prime_next = 1'b0;
                    if (u_reg == '0 && v_reg == WIDTH'(1) && n_reg > WIDTH'(1))
                    begin
                        // Coprime with a modulus of two or more: run the power.
                        e_next     = n_reg - WIDTH'(1);
                        acc_next   = WIDTH'(1);
                        state_next = ST_PSTEP;
                    end
                    else if (v_reg == '0 && u_reg == WIDTH'(1) && n_reg > WIDTH'(1))
                    begin
                        e_next     = n_reg - WIDTH'(1);
                        acc_next   = WIDTH'(1);
                        state_next = ST_PSTEP;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
                else if (!u_reg[0])
                begin
                    u_next = u_reg >> 1;
                end
                else if (!v_reg[0])
                begin
                    v_next = v_reg >> 1;
                end
                else if (!gcd_diff[WIDTH])
                begin
                    u_next = gcd_diff[WIDTH-1:0];
                end
                else
                begin
                    v_next = v_reg - u_reg;
                end
            end

            ST_PSTEP:
            begin
                // Next exponent bit, lowest first.
                if (e_reg == '0)
                begin
                    prime_next = (acc_reg == WIDTH'(1));
                    state_next = ST_FIN;
                end
                else if (e_reg[0])
                begin
                    mx_next      = acc_reg;
                    my_next      = a_reg;
                    mp_next      = '0;
                    sq_mode_next = 1'b0;
                    state_next   = ST_MUL;
                end
                else
                begin
                    mx_next      = a_reg;
                    my_next      = a_reg;
                    mp_next      = '0;
                    sq_mode_next = 1'b1;
                    state_next   = ST_MUL;
                end
            end

            ST_MUL:
            begin
                // Shift-and-add modular product, one multiplier bit a cycle.
                if (my_reg == '0)
                begin
                    if (!sq_mode_reg)
                    begin
                        acc_next     = mp_reg;
                        mx_next      = a_reg;
                        my_next      = a_reg;
                        mp_next      = '0;
                        sq_mode_next = 1'b1;
                    end
                    else
                    begin
                        a_next     = mp_reg;
                        e_next     = e_reg >> 1;
                        state_next = ST_PSTEP;
                    end
                end
                else
                begin
                    if (my_reg[0])
                        mp_next = add_mod(mp_reg, mx_reg, n_reg);
                    mx_next = add_mod(mx_reg, mx_reg, n_reg);
                    my_next = my_reg >> 1;
                end
            end

            ST_FIN:
            begin
                if (res_free)
                begin
                    res_next.probable_prime = prime_reg;
                    res_next.coprime        = cop_reg;
                    res_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        sq_mode_reg <= sq_mode_next;
        n_reg       <= n_next;
        div_reg     <= div_next;
        rem_reg     <= rem_next;
        u_reg       <= u_next;
        v_reg       <= v_next;
        a_reg       <= a_next;
        acc_reg     <= acc_next;
        e_reg       <= e_next;
        mx_reg      <= mx_next;
        my_reg      <= my_next;
        mp_reg      <= mp_next;
        cop_reg     <= cop_next;
        prime_reg   <= prime_next;
        res_reg     <= res_next;
    end

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for fermat_base_test_core.
// Sends base/modulus pairs, predicts each verdict with its own gcd and
// modular-power model, and checks every result transfer. Depends on fbt_pkg.
`timescale 1ns / 1ps

module tb_top;
    import fbt_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int TAIL_CYCLES = 2500;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     arg_valid = 1'b0;
    logic     arg_stall;
    fbt_arg_t arg       = '0;
    logic     res_valid;
    logic     res_stall = 1'b0;
    fbt_res_t res;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int error_count   = 0;
    int cycle_count   = 0;

    // Verdicts still owed by the core, oldest first, with their arguments.
    fbt_res_t pending_verdicts[$];
    fbt_arg_t pending_args[$];

    fermat_base_test_core #(.WIDTH(32)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .arg_valid (arg_valid),
        .arg_stall (arg_stall),
        .arg       (arg),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // Clock generation.
    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Timeout guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Reduces the base, takes the gcd, and runs square-and-multiply when the
    // pair is coprime and the modulus is at least two.
    function automatic fbt_res_t fermat_verdict(input fbt_arg_t item);
        bit [63:0] a;
        bit [63:0] n;
        bit [63:0] x;
        bit [63:0] y;
        bit [63:0] r;
        bit [63:0] power;
        bit [63:0] square;
        bit [63:0] expo;
        fbt_res_t  verdict;
        a = item.base;
        n = item.modulus;
        if (n != 0)
            a = a % n;
        x = a;
        y = n;
        while (y != 0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        verdict.coprime = (x == 1);
        verdict.probable_prime = 1'b0;
        if (verdict.coprime && n >= 2)
        begin
            power  = 1;
            square = a;
            expo   = n - 1;
            // Operands stay below 2^32, so each product fits in 64 bits.
            while (expo != 0)
            begin
                if (expo[0])
                    power = (power * square) % n;
                square = (square * square) % n;
                expo = expo >> 1;
            end
            verdict.probable_prime = (power == 1);
        end
        return verdict;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Result checking and receiver stall generation.
    always @(posedge clk)
    begin : result_check
        fbt_res_t want;
        fbt_arg_t src;
        if (res_valid && !res_stall)
        begin
            if (pending_verdicts.size() == 0)
            begin
                report_mismatch($sformatf("result transfer %b with nothing outstanding", res));
            end
            else
            begin
                want = pending_verdicts.pop_front();
                src  = pending_args.pop_front();
                if (res.probable_prime !== want.probable_prime)
                    report_mismatch($sformatf("base %0d modulus %0d: probable_prime %b, want %b",
                        src.base, src.modulus, res.probable_prime, want.probable_prime));
                if (res.coprime !== want.coprime)
                    report_mismatch($sformatf("base %0d modulus %0d: coprime %b, want %b",
                        src.base, src.modulus, res.coprime, want.coprime));
            end
        end
        res_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end

    // Drives one argument transfer, with an optional sender gap first, and
    // records its verdict once the core takes it.
    task automatic send_arg(input logic [31:0] base, input logic [31:0] modulus);
        fbt_arg_t item;
        item.base    = base;
        item.modulus = modulus;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            arg_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        arg       <= item;
        arg_valid <= 1'b1;
        do @(posedge clk); while (arg_stall);
        pending_verdicts.push_back(fermat_verdict(item));
        pending_args.push_back(item);
    endtask

    task automatic wait_for_results();
        arg_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] known_prime(input int idx);
        case (idx)
            0:       return 32'd2;
            1:       return 32'd3;
            2:       return 32'd97;
            3:       return 32'd7919;
            4:       return 32'd65521;
            5:       return 32'd65537;
            6:       return 32'd1000003;
            7:       return 32'd998244353;
            8:       return 32'd1000000007;
            9:       return 32'd2147483647;
            default: return 32'd4294967291;
        endcase
    endfunction

    // Carmichael numbers and a base-2 pseudoprime: they fool the test.
    function automatic logic [31:0] fermat_liar(input int idx);
        case (idx)
            0:       return 32'd341;
            1:       return 32'd561;
            2:       return 32'd1105;
            3:       return 32'd1729;
            4:       return 32'd2465;
            5:       return 32'd8911;
            6:       return 32'd41041;
            7:       return 32'd825265;
            default: return 32'd3215031751;
        endcase
    endfunction

    // Extremes of both fields, including all-ones and single-bit patterns.
    task automatic test_field_extremes();
        send_arg(32'd0, 32'd2);
        send_arg(32'd1, 32'd2);
        send_arg(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_arg(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_arg(32'd2, 32'd4294967291);
        send_arg(32'hFFFF_FFFF, 32'd4294967291);
        send_arg(32'h8000_0000, 32'h7FFF_FFFF);
        send_arg(32'h5555_5555, 32'hAAAA_AAAB);
        send_arg(32'hAAAA_AAAA, 32'h8000_0000);
        wait_for_results();
    endtask

    // Zero and one moduli, bases that are multiples of the modulus, an even
    // modulus, and moduli that pass the test without being prime.
    task automatic test_special_cases();
        send_arg(32'd1, 32'd0);
        send_arg(32'd5, 32'd0);
        send_arg(32'd0, 32'd0);
        send_arg(32'hFFFF_FFFF, 32'd0);
        send_arg(32'd7, 32'd1);
        send_arg(32'd0, 32'd1);
        send_arg(32'd21, 32'd7);
        send_arg(32'd0, 32'd97);
        send_arg(32'd97, 32'd97);
        send_arg(32'd3, 32'd4);
        send_arg(32'd2, 32'd341);
        send_arg(32'd3, 32'd341);
        send_arg(32'd2, 32'd561);
        send_arg(32'd3, 32'd561);
        wait_for_results();
    endtask

    // Random pairs: half of the moduli are primes and Fermat liars so both verdicts
    // show up often, the rest random moduli of random size.
    task automatic test_random_traffic(input int count, input int idle, input int stall);
        logic [31:0] base;
        logic [31:0] modulus;
        int          pick;
        send_idle_pct = idle;
        stall_pct     = stall;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                modulus = known_prime($urandom_range(0, 10));
            else if (pick < 50)
                modulus = fermat_liar($urandom_range(0, 8));
            else
                modulus = $urandom >> $urandom_range(0, 30);
            pick = $urandom_range(0, 99);
            if (pick < 8)
                base = modulus * $urandom_range(0, 3);
            else if (pick < 40)
                base = $urandom;
            else
                base = $urandom >> $urandom_range(0, 31);
            send_arg(base, modulus);
        end
        wait_for_results();
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    // Test sequence.
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_special_cases();
        test_random_traffic(30, 0, 0);
        test_random_traffic(30, 46, 0);
        test_random_traffic(30, 0, 46);
        test_random_traffic(30, 33, 33);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/fbt_pkg.sv
rtl/fermat_base_test_core.sv
sim/tb_top.sv
